// File: design/lpt_pkg.sv
// shared constants, codes and types for the load percent and pre-torque block
package lpt_pkg;

   localparam int FLOOR_COUNT = 64;
   localparam int FLOOR_IDX_W = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
   localparam int RANGE_W     = 9;

   localparam int FLOOR_W  = 6;
   localparam int RAW_W    = 10;
   localparam int TBL_W    = 11;
   localparam int PCT_W    = 20;
   localparam int LOAD_W   = 17;
   localparam int TORQUE_W = 15;
   localparam int LIMIT_W  = 8;
   localparam int BAL_W    = 10;
   localparam int GAIN_W   = 14;
   localparam int ABS_W    = 10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam int DIV_W     = 24;
   localparam int DIVISOR_W = 11;
   localparam int DIV_CNT_W = 5;
   localparam int LREM_W    = 4;

   localparam int PCT_SCALE   = 1000;
   localparam int TORQUE_MAX  = 10000;
   localparam int TORQUE_SPAN = 1000;
   localparam int BAND_TENTHS = 50;
   localparam int LOAD_DIV    = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS       = 3'd0,
      CSR_ANTINUISANCE = 3'd1,
      CSR_DISPATCH     = 3'd2,
      CSR_OVERLOAD     = 3'd3,
      CSR_WHEELCHAIR   = 3'd4,
      CSR_BALANCE      = 3'd5,
      CSR_GAIN_UP      = 3'd6,
      CSR_GAIN_DOWN    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_BALANCED = 2'd0,
      DIR_UP       = 2'd1,
      DIR_DOWN     = 2'd2,
      DIR_FAULT    = 2'd3
   } dir_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic step;
      logic last;
      logic q_bit;
   } div_stat_type;

endpackage

// File: design/lpt_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle, msb first
module lpt_sdiv (
   input  logic                                clock,
   input  logic                                reset,
   input  lpt_pkg::div_cmd_type                cmd,
   input  logic [lpt_pkg::DIV_W-1:0]           dividend,
   input  logic [lpt_pkg::DIVISOR_W-1:0]       divisor,
   output lpt_pkg::div_stat_type               stat,
   output logic [lpt_pkg::DIV_W-1:0]           quotient
);

   logic                              active_ff, active_in;
   logic [lpt_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lpt_pkg::DIV_W-1:0]         num_ff, num_in;
   logic [lpt_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [lpt_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [lpt_pkg::DIVISOR_W-1:0]     dsr_ff, dsr_in;
   logic [lpt_pkg::DIVISOR_W:0]       trial;
   logic [lpt_pkg::DIVISOR_W:0]       trial_sub;
   logic                              fits;

   assign trial     = {rem_ff, num_ff[lpt_pkg::DIV_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign fits      = trial >= {1'b0, dsr_ff};

   assign stat.step  = active_ff;
   assign stat.last  = active_ff && (cnt_ff == lpt_pkg::DIV_CNT_W'(1));
   assign stat.q_bit = fits;
   assign quotient   = {quo_ff[lpt_pkg::DIV_W-2:0], fits};

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (cmd.start) begin
         active_in = cmd.steps != '0;
         cnt_in    = cmd.steps;
         num_in    = dividend;
         quo_in    = '0;
         rem_in    = '0;
         dsr_in    = divisor;
      end else if (active_ff) begin
         active_in = cnt_ff != lpt_pkg::DIV_CNT_W'(1);
         cnt_in    = cnt_ff - lpt_pkg::DIV_CNT_W'(1);
         num_in    = {num_ff[lpt_pkg::DIV_W-2:0], 1'b0};
         quo_in    = {quo_ff[lpt_pkg::DIV_W-2:0], fits};
         rem_in    = fits ? trial_sub[lpt_pkg::DIVISOR_W-1:0] : trial[lpt_pkg::DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

// File: design/load_percent_and_pretorque.sv
// top level: floor table, load percent, threshold flags, balance and pre-torque
//
//  channel | ports                          | moves
//  req     | req_valid / req_ready, req_*   | table write or evaluate request
//  rsp     | rsp_valid / rsp_ready, rsp_*   | one result per evaluate request
//  csr     | csr_write_en, csr_index, data  | register write, no wait
//
// a table write is stored as the request is taken; an evaluate passes lookup, a load division
// in the serial divider when updating (20 quotient bits), evaluation, a pre-torque division
// when the torque is scaled (24 quotient bits) and the output state
// synchronous reset clears the state, configuration, held percent and load, and the sticky error, not the table
// a finished result sits in the output register; the next request is taken meanwhile
module load_percent_and_pretorque (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [lpt_pkg::FLOOR_W-1:0]           req_floor,
   input  logic [lpt_pkg::RAW_W-1:0]             req_raw_reading,
   input  logic [lpt_pkg::TBL_W-1:0]             req_empty_value,
   input  logic [lpt_pkg::TBL_W-1:0]             req_full_value,
   input  logic                                  req_weigher_ok,
   input  logic                                  req_update_allowed,
   input  logic                                  req_calibrating,
   input  logic                                  req_moving_down,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lpt_pkg::PCT_W-1:0]             rsp_percent_tenths,
   output logic [lpt_pkg::LOAD_W-1:0]            rsp_load_whole,
   output logic                                  rsp_bypass_flag,
   output logic                                  rsp_antinuisance_flag,
   output logic                                  rsp_dispatch_flag,
   output logic                                  rsp_overload_flag,
   output logic                                  rsp_no_wheelchair_flag,
   output logic [1:0]                            rsp_balance_direction,
   output logic signed [lpt_pkg::TORQUE_W-1:0]   rsp_pre_torque,
   output logic                                  rsp_table_error,
   output logic                                  rsp_request_read,
   input  logic                                  csr_write_en,
   input  logic [lpt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lpt_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_DIV1   = 6'b000100,
      ST_EVAL   = 6'b001000,
      ST_DIV2   = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   localparam int ENTRY_W = 2 * lpt_pkg::TBL_W;
   localparam int WIDE_W  = lpt_pkg::PCT_W + 1;

   // configuration registers
   logic [lpt_pkg::LIMIT_W-1:0]  bypass_lim_ff, antin_lim_ff, disp_lim_ff, ovl_lim_ff, wchr_lim_ff;
   logic [lpt_pkg::BAL_W-1:0]    bal_ff;
   logic [lpt_pkg::GAIN_W-1:0]   gain_up_ff, gain_dn_ff;

   // floor table
   logic [ENTRY_W-1:0]               tbl_mem [lpt_pkg::FLOOR_COUNT];
   logic [ENTRY_W-1:0]               rd_ff;
   logic [lpt_pkg::FLOOR_IDX_W-1:0]  req_idx;
   logic                             req_in_range;
   logic                             req_take;

   state_type                     state_ff, state_in;
   logic [lpt_pkg::RAW_W-1:0]     raw_ff;
   logic                          wok_ff, upd_ff, cal_ff, down_ff, range_ff;
   logic                          usable_ff, usable_in;
   logic                          reqrd_ff, reqrd_in;
   logic [lpt_pkg::PCT_W-1:0]     held_pct_ff, held_pct_in;
   logic [lpt_pkg::LOAD_W-1:0]    held_load_ff, held_load_in;
   logic                          err_ff, err_in;
   logic [lpt_pkg::LREM_W-1:0]    lrem_ff, lrem_in;
   logic [lpt_pkg::LOAD_W-1:0]    lq_ff, lq_in;
   logic [4:0]                    flags_ff, flags_in;
   logic [1:0]                    dir_ff, dir_in;
   logic [lpt_pkg::TORQUE_W-1:0]  tq_ff, tq_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;

   logic [lpt_pkg::PCT_W-1:0]     rsp_pct_ff;
   logic [lpt_pkg::LOAD_W-1:0]    rsp_load_ff;
   logic [4:0]                    rsp_flags_ff;
   logic [1:0]                    rsp_dir_ff;
   logic [lpt_pkg::TORQUE_W-1:0]  rsp_tq_ff;
   logic                          rsp_err_ff, rsp_reqrd_ff;

   // lookup stage
   logic [lpt_pkg::TBL_W-1:0]     ent_empty, ent_full, span;
   logic [lpt_pkg::TBL_W-1:0]     raw_diff;
   logic                          full_above, raw_above;
   logic [lpt_pkg::PCT_W-1:0]     numer;
   logic                          usable_now, do_update;

   // load tracking and evaluation
   logic [lpt_pkg::LREM_W:0]      ltrial;
   logic                          lfit;
   logic signed [WIDE_W-1:0]      dev;
   logic [WIDE_W-1:0]             dev_abs;
   logic                          dev_over, dev_under;
   logic [lpt_pkg::GAIN_W-1:0]    gain_sel;
   logic [lpt_pkg::DIV_W-1:0]     product;
   logic [4:0]                    flags_now;
   logic [1:0]                    dir_now;
   logic [lpt_pkg::DIV_W-1:0]     tq_mag;

   lpt_pkg::div_cmd_type          div_cmd;
   lpt_pkg::div_stat_type         div_stat;
   logic [lpt_pkg::DIV_W-1:0]     div_dividend, div_quotient;
   logic [lpt_pkg::DIVISOR_W-1:0] div_divisor;

   lpt_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign req_ready    = state_ff == ST_IDLE;
   assign req_take     = req_valid && req_ready;
   assign req_idx      = lpt_pkg::FLOOR_IDX_W'(req_floor);
   assign req_in_range = lpt_pkg::RANGE_W'(req_floor) < lpt_pkg::RANGE_W'(lpt_pkg::FLOOR_COUNT);

   always_ff @(posedge clock) begin
      if (req_take && !req_kind && req_in_range) begin
         tbl_mem[req_idx] <= {req_empty_value, req_full_value};
      end
      if (req_take && req_kind) begin
         rd_ff <= tbl_mem[req_idx];
      end
   end

   // lookup arithmetic
   assign ent_empty  = rd_ff[ENTRY_W-1:lpt_pkg::TBL_W];
   assign ent_full   = rd_ff[lpt_pkg::TBL_W-1:0];
   assign full_above = ent_full > ent_empty;
   assign raw_above  = lpt_pkg::TBL_W'(raw_ff) >= ent_empty;
   assign span       = ent_full - ent_empty;
   assign raw_diff   = lpt_pkg::TBL_W'(raw_ff) - ent_empty;
   assign numer      = lpt_pkg::PCT_W'(raw_diff[lpt_pkg::RAW_W-1:0])
                       * lpt_pkg::PCT_W'(lpt_pkg::PCT_SCALE);
   assign usable_now = wok_ff && !err_ff;
   assign do_update  = usable_now && upd_ff && range_ff;

   // load in whole percent, divided by ten as the quotient bits come out
   assign ltrial = {lrem_ff, div_stat.q_bit};
   assign lfit   = ltrial >= (lpt_pkg::LREM_W + 1)'(lpt_pkg::LOAD_DIV);

   // evaluation arithmetic
   assign dev       = $signed({1'b0, held_pct_ff}) - $signed(WIDE_W'(bal_ff));
   assign dev_abs   = dev[WIDE_W-1] ? WIDE_W'(-dev) : WIDE_W'(dev);
   assign dev_over  = dev > $signed(WIDE_W'(lpt_pkg::TORQUE_SPAN));
   assign dev_under = dev < -$signed(WIDE_W'(lpt_pkg::TORQUE_SPAN));
   assign gain_sel  = (gain_dn_ff != '0 && down_ff) ? gain_dn_ff : gain_up_ff;
   assign product   = lpt_pkg::DIV_W'(gain_sel) * lpt_pkg::DIV_W'(dev_abs[lpt_pkg::ABS_W-1:0]);
   assign tq_mag    = (div_quotient > lpt_pkg::DIV_W'(lpt_pkg::TORQUE_MAX))
                      ? lpt_pkg::DIV_W'(lpt_pkg::TORQUE_MAX) : div_quotient;

   always_comb begin
      flags_now[0] = bypass_lim_ff != '0 && held_load_ff > lpt_pkg::LOAD_W'(bypass_lim_ff);
      flags_now[1] = antin_lim_ff != '0 && held_load_ff < lpt_pkg::LOAD_W'(antin_lim_ff);
      flags_now[2] = disp_lim_ff != '0 && held_load_ff > lpt_pkg::LOAD_W'(disp_lim_ff);
      flags_now[3] = ovl_lim_ff != '0 && held_load_ff > lpt_pkg::LOAD_W'(ovl_lim_ff);
      flags_now[4] = wchr_lim_ff != '0 && held_load_ff > lpt_pkg::LOAD_W'(wchr_lim_ff);
      if (WIDE_W'(held_pct_ff) + WIDE_W'(lpt_pkg::BAND_TENTHS) < WIDE_W'(bal_ff)) begin
         dir_now = lpt_pkg::DIR_UP;
      end else if (WIDE_W'(held_pct_ff) > WIDE_W'(bal_ff) + WIDE_W'(lpt_pkg::BAND_TENTHS)) begin
         dir_now = lpt_pkg::DIR_DOWN;
      end else begin
         dir_now = lpt_pkg::DIR_BALANCED;
      end
   end

   always_comb begin
      state_in     = state_ff;
      usable_in    = usable_ff;
      reqrd_in     = reqrd_ff;
      held_pct_in  = held_pct_ff;
      held_load_in = held_load_ff;
      err_in       = err_ff;
      lrem_in      = lrem_ff;
      lq_in        = lq_ff;
      flags_in     = flags_ff;
      dir_in       = dir_ff;
      tq_in        = tq_ff;
      neg_in       = neg_ff;
      rsp_load     = 1'b0;
      div_cmd      = '0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_kind) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            usable_in = usable_now;
            reqrd_in  = usable_now && upd_ff && !cal_ff;
            if (!usable_now) begin
               held_pct_in = lpt_pkg::PCT_W'(bal_ff);
               state_in    = ST_EVAL;
            end else if (do_update) begin
               div_cmd.start = 1'b1;
               div_cmd.steps = lpt_pkg::DIV_CNT_W'(lpt_pkg::PCT_W);
               div_dividend  = {(full_above && raw_above) ? numer : '0,
                                (lpt_pkg::DIV_W - lpt_pkg::PCT_W)'(0)};
               div_divisor   = full_above ? span : lpt_pkg::DIVISOR_W'(1);
               if (!full_above) begin
                  err_in = 1'b1;
               end
               lrem_in  = '0;
               lq_in    = '0;
               state_in = ST_DIV1;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_DIV1: begin
            if (div_stat.step) begin
               lrem_in = lfit ? lpt_pkg::LREM_W'(ltrial - (lpt_pkg::LREM_W + 1)'(lpt_pkg::LOAD_DIV))
                              : lpt_pkg::LREM_W'(ltrial);
               lq_in   = {lq_ff[lpt_pkg::LOAD_W-2:0], lfit};
            end
            if (div_stat.last) begin
               held_pct_in  = div_quotient[lpt_pkg::PCT_W-1:0];
               held_load_in = {lq_ff[lpt_pkg::LOAD_W-2:0], lfit};
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (usable_ff) begin
               flags_in = flags_now;
               dir_in   = dir_now;
            end else begin
               flags_in = '0;
               dir_in   = lpt_pkg::DIR_FAULT;
            end
            state_in = ST_OUT;
            if (!usable_ff || gain_up_ff == '0 || err_ff) begin
               tq_in = '0;
            end else if (dev_over) begin
               tq_in = lpt_pkg::TORQUE_W'(lpt_pkg::TORQUE_MAX);
            end else if (dev_under) begin
               tq_in = -lpt_pkg::TORQUE_W'(lpt_pkg::TORQUE_MAX);
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = lpt_pkg::DIV_CNT_W'(lpt_pkg::DIV_W);
               div_dividend  = product;
               div_divisor   = lpt_pkg::DIVISOR_W'(lpt_pkg::TORQUE_SPAN);
               neg_in        = dev[WIDE_W-1];
               state_in      = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_stat.last) begin
               tq_in    = neg_ff ? -lpt_pkg::TORQUE_W'(tq_mag) : lpt_pkg::TORQUE_W'(tq_mag);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_pct_ff   <= '0;
         held_load_ff  <= '0;
         err_ff        <= 1'b0;
         bypass_lim_ff <= '0;
         antin_lim_ff  <= '0;
         disp_lim_ff   <= '0;
         ovl_lim_ff    <= '0;
         wchr_lim_ff   <= '0;
         bal_ff        <= '0;
         gain_up_ff    <= '0;
         gain_dn_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_pct_ff  <= held_pct_in;
         held_load_ff <= held_load_in;
         err_ff       <= err_in;
         if (csr_write_en) begin
            case (lpt_pkg::csr_index_type'(csr_index))
               lpt_pkg::CSR_BYPASS:       bypass_lim_ff <= csr_wdata[lpt_pkg::LIMIT_W-1:0];
               lpt_pkg::CSR_ANTINUISANCE: antin_lim_ff  <= csr_wdata[lpt_pkg::LIMIT_W-1:0];
               lpt_pkg::CSR_DISPATCH:     disp_lim_ff   <= csr_wdata[lpt_pkg::LIMIT_W-1:0];
               lpt_pkg::CSR_OVERLOAD:     ovl_lim_ff    <= csr_wdata[lpt_pkg::LIMIT_W-1:0];
               lpt_pkg::CSR_WHEELCHAIR:   wchr_lim_ff   <= csr_wdata[lpt_pkg::LIMIT_W-1:0];
               lpt_pkg::CSR_BALANCE:      bal_ff        <= csr_wdata[lpt_pkg::BAL_W-1:0];
               lpt_pkg::CSR_GAIN_UP:      gain_up_ff    <= csr_wdata[lpt_pkg::GAIN_W-1:0];
               lpt_pkg::CSR_GAIN_DOWN:    gain_dn_ff    <= csr_wdata[lpt_pkg::GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_kind) begin
         raw_ff   <= req_raw_reading;
         wok_ff   <= req_weigher_ok;
         upd_ff   <= req_update_allowed;
         cal_ff   <= req_calibrating;
         down_ff  <= req_moving_down;
         range_ff <= req_in_range;
      end
      usable_ff <= usable_in;
      reqrd_ff  <= reqrd_in;
      lrem_ff   <= lrem_in;
      lq_ff     <= lq_in;
      flags_ff  <= flags_in;
      dir_ff    <= dir_in;
      tq_ff     <= tq_in;
      neg_ff    <= neg_in;
      if (rsp_load) begin
         rsp_pct_ff   <= held_pct_ff;
         rsp_load_ff  <= held_load_ff;
         rsp_flags_ff <= flags_ff;
         rsp_dir_ff   <= dir_ff;
         rsp_tq_ff    <= tq_ff;
         rsp_err_ff   <= err_ff;
         rsp_reqrd_ff <= reqrd_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_percent_tenths     = rsp_pct_ff;
   assign rsp_load_whole         = rsp_load_ff;
   assign rsp_bypass_flag        = rsp_flags_ff[0];
   assign rsp_antinuisance_flag  = rsp_flags_ff[1];
   assign rsp_dispatch_flag      = rsp_flags_ff[2];
   assign rsp_overload_flag      = rsp_flags_ff[3];
   assign rsp_no_wheelchair_flag = rsp_flags_ff[4];
   assign rsp_balance_direction  = rsp_dir_ff;
   assign rsp_pre_torque         = $signed(rsp_tq_ff);
   assign rsp_table_error        = rsp_err_ff;
   assign rsp_request_read       = rsp_reqrd_ff;

endmodule

// File: design/lpt_check.sv
// port-level checks for the load percent and pre-torque block, bound to the top level
module lpt_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_kind,
   input logic [lpt_pkg::FLOOR_W-1:0]           req_floor,
   input logic [lpt_pkg::RAW_W-1:0]             req_raw_reading,
   input logic [lpt_pkg::TBL_W-1:0]             req_empty_value,
   input logic [lpt_pkg::TBL_W-1:0]             req_full_value,
   input logic                                  req_weigher_ok,
   input logic                                  req_update_allowed,
   input logic                                  req_calibrating,
   input logic                                  req_moving_down,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [lpt_pkg::PCT_W-1:0]             rsp_percent_tenths,
   input logic [lpt_pkg::LOAD_W-1:0]            rsp_load_whole,
   input logic                                  rsp_bypass_flag,
   input logic                                  rsp_antinuisance_flag,
   input logic                                  rsp_dispatch_flag,
   input logic                                  rsp_overload_flag,
   input logic                                  rsp_no_wheelchair_flag,
   input logic [1:0]                            rsp_balance_direction,
   input logic signed [lpt_pkg::TORQUE_W-1:0]   rsp_pre_torque,
   input logic                                  rsp_table_error,
   input logic                                  rsp_request_read,
   input logic                                  csr_write_en,
   input logic [lpt_pkg::CSR_IDX_W-1:0]         csr_index,
   input logic [lpt_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_percent_tenths)
                                  && $stable(rsp_pre_torque))
      else $error("result changed while stalled");

   a_torque_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pre_torque <= $signed(16'(lpt_pkg::TORQUE_MAX))
                    && rsp_pre_torque >= -$signed(16'(lpt_pkg::TORQUE_MAX)))
      else $error("pre-torque outside clamp");

   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_balance_direction == lpt_pkg::DIR_FAULT |->
         rsp_pre_torque == '0 && !rsp_request_read && !rsp_bypass_flag
         && !rsp_antinuisance_flag && !rsp_dispatch_flag && !rsp_overload_flag
         && !rsp_no_wheelchair_flag)
      else $error("unusable weigher result not quiet");

   a_error_no_torque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_error |-> rsp_pre_torque == '0)
      else $error("pre-torque with table error");

endmodule

bind load_percent_and_pretorque lpt_check u_lpt_check (.*);
